### hdl/hrt_pkg.sv
// Shared types, codes and default sizes for the hashed route table.
package hrt_pkg;

    localparam int unsigned FIELD_W       = 8;
    localparam int unsigned MODE_W        = 2;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned LUT_N         = 1 << FIELD_W;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam int unsigned DEF_BUCKETS   = 16;
    localparam int unsigned DEF_WAYS      = 4;
    localparam int unsigned DEF_NODE_BITS = 8;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] dest_node;
        logic [FIELD_W-1:0] next_hop_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  next_hop_out;
    } t_rsp;

    typedef struct packed {
        logic clearing;
        logic retire;
    } t_back_status;

endpackage

### hdl/hrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hrt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/hrt_front.sv
// Request front end: key masking, bucket mapping and queue push.
module hrt_front import hrt_pkg::*; #(
    parameter int unsigned BUCKETS   = DEF_BUCKETS,
    parameter int unsigned NODE_BITS = DEF_NODE_BITS,
    localparam int unsigned BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int unsigned QW       = MODE_W + BKT_W + 2 * NODE_BITS
) (
    input  logic          i_req_valid,
    input  t_req          i_req,
    input  logic          i_clearing,
    input  logic          i_q_full,
    output logic          o_req_stall,
    output logic          o_push,
    output logic [QW-1:0] o_push_data
);

    logic [NODE_BITS-1:0] key;
    logic [NODE_BITS-1:0] hop;
    logic [FIELD_W-1:0]   lut_idx;
    logic [BKT_W-1:0]     bkt_lut [LUT_N];
    logic [BKT_W-1:0]     bucket;

    // IDs narrower or wider than the port field are masked / zero extended
    for (genvar i = 0; i < NODE_BITS; i++) begin : g_key
        if (i < FIELD_W) begin : g_in
            assign key[i] = i_req.dest_node[i];
            assign hop[i] = i_req.next_hop_in[i];
        end else begin : g_pad
            assign key[i] = 1'b0;
            assign hop[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < FIELD_W; i++) begin : g_idx
        if (i < NODE_BITS) begin : g_in
            assign lut_idx[i] = i_req.dest_node[i];
        end else begin : g_pad
            assign lut_idx[i] = 1'b0;
        end
    end

    // key modulo bucket count, resolved at elaboration
    for (genvar k = 0; k < LUT_N; k++) begin : g_lut
        localparam int unsigned BktVal = k % BUCKETS;
        assign bkt_lut[k] = BKT_W'(BktVal);
    end

    assign bucket      = bkt_lut[lut_idx];
    assign o_req_stall = i_q_full | i_clearing;
    assign o_push      = i_req_valid & ~o_req_stall;
    assign o_push_data = {i_req.mode, bucket, key, hop};

endmodule

### hdl/hrt_queue.sv
// Small flop-based FIFO between front end and table engine.
module hrt_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

### hdl/hrt_back.sv
// Table engine: clearing pass, bucket read, compare and row write-back.
module hrt_back import hrt_pkg::*; #(
    parameter int unsigned BUCKETS   = DEF_BUCKETS,
    parameter int unsigned WAYS      = DEF_WAYS,
    parameter int unsigned NODE_BITS = DEF_NODE_BITS,
    localparam int unsigned BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int unsigned QW       = MODE_W + BKT_W + 2 * NODE_BITS,
    localparam int unsigned EW       = 1 + 2 * NODE_BITS,
    localparam int unsigned RW       = WAYS * EW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  logic [QW-1:0] i_q_data,
    output logic          o_pop,
    output logic          o_ram_we,
    output logic [BKT_W-1:0] o_ram_waddr,
    output logic [RW-1:0] o_ram_wdata,
    output logic          o_ram_re,
    output logic [BKT_W-1:0] o_ram_raddr,
    input  logic [RW-1:0] i_ram_rdata,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output t_rsp          o_rsp,
    output t_back_status  o_status
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    localparam logic [BKT_W-1:0] LastBkt = BKT_W'(BUCKETS - 1);
    localparam int unsigned VB = 2 * NODE_BITS;

    t_state           r_state, n_state;
    logic [BKT_W-1:0] r_clr_addr, n_clr_addr;
    logic [QW-1:0]    r_cur, n_cur;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic [MODE_W-1:0]    cur_mode;
    logic [BKT_W-1:0]     cur_bucket;
    logic [NODE_BITS-1:0] cur_key;
    logic [NODE_BITS-1:0] cur_hop;
    logic [BKT_W-1:0]     q_bucket;

    logic [WAYS-1:0]      match;
    logic [WAYS-1:0]      free;
    logic [WAYS-1:0]      first_free;
    logic [NODE_BITS-1:0] hit_hop;
    logic [FIELD_W-1:0]   hit_hop8;
    logic [RW-1:0]        new_row;
    t_rsp                 result;
    logic                 retire;

    assign cur_hop    = r_cur[0 +: NODE_BITS];
    assign cur_key    = r_cur[NODE_BITS +: NODE_BITS];
    assign cur_bucket = r_cur[2 * NODE_BITS +: BKT_W];
    assign cur_mode   = r_cur[2 * NODE_BITS + BKT_W +: MODE_W];
    assign q_bucket   = i_q_data[2 * NODE_BITS +: BKT_W];

    always_comb begin
        match   = '0;
        free    = '0;
        hit_hop = '0;
        for (int w = 0; w < WAYS; w++) begin
            free[w]  = ~i_ram_rdata[w * EW + VB];
            match[w] = i_ram_rdata[w * EW + VB]
                     & (i_ram_rdata[w * EW + NODE_BITS +: NODE_BITS] == cur_key);
            if (match[w]) begin
                hit_hop = hit_hop | i_ram_rdata[w * EW +: NODE_BITS];
            end
        end
    end

    // isolate lowest free way
    assign first_free = free & (~free + 1'b1);

    for (genvar i = 0; i < FIELD_W; i++) begin : g_hop8
        if (i < NODE_BITS) begin : g_in
            assign hit_hop8[i] = hit_hop[i];
        end else begin : g_pad
            assign hit_hop8[i] = 1'b0;
        end
    end

    always_comb begin
        new_row = i_ram_rdata;
        result  = '{status: STATUS_OK, next_hop_out: '0};
        case (cur_mode)
            MODE_LOOKUP: begin
                if (|match) begin
                    result.next_hop_out = hit_hop8;
                end else begin
                    result.status = STATUS_MISS;
                end
            end
            MODE_SET: begin
                if (|match) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (match[w]) begin
                            new_row[w * EW +: NODE_BITS] = cur_hop;
                        end
                    end
                end else if (|free) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (first_free[w]) begin
                            new_row[w * EW +: EW] = {1'b1, cur_key, cur_hop};
                        end
                    end
                end else begin
                    result.status = STATUS_FULL;
                end
            end
            MODE_DELETE: begin
                if (|match) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (match[w]) begin
                            new_row[w * EW + VB] = 1'b0;
                        end
                    end
                end else begin
                    result.status = STATUS_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_clr_addr;
        o_ram_wdata = '0;
        o_ram_raddr = q_bucket;
        retire      = 1'b0;
        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_ram_we = 1'b1;
                if (r_clr_addr == LastBkt) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    o_ram_re = 1'b1;
                    n_cur    = i_q_data;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result slot free or being drained this cycle
                if (!r_out_valid || !i_rsp_stall) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = cur_bucket;
                    o_ram_wdata = new_row;
                    n_out_valid = 1'b1;
                    n_out       = result;
                    n_state     = ST_IDLE;
                    retire      = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_rsp             = r_out;
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.retire   = retire;

endmodule

### hdl/hashed_route_table_core.sv
// Top level of the hashed next-hop route table.
//
//  channel | dir | payload | handshake
//  --------+-----+---------+--------------------------------------------
//  req     | in  | t_req   | i_req_valid / o_req_stall
//  rsp     | out | t_rsp   | o_rsp_valid / i_rsp_stall
//
// In the table engine each request first has its bucket row read from the row RAM;
// then all ways are compared and the row is written back.
// After reset a clearing pass writes every bucket row with o_req_stall held
// high; no request is taken during it.
// A two-entry queue decouples intake from the engine; one finished response
// waits in the output register while the engine stalls on a held rsp.
module hashed_route_table_core import hrt_pkg::*; #(
    parameter int unsigned BUCKETS   = DEF_BUCKETS,
    parameter int unsigned WAYS      = DEF_WAYS,
    parameter int unsigned NODE_BITS = DEF_NODE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned QW    = MODE_W + BKT_W + 2 * NODE_BITS;
    localparam int unsigned RW    = WAYS * (1 + 2 * NODE_BITS);

    logic             push;
    logic [QW-1:0]    push_data;
    logic             pop;
    logic [QW-1:0]    q_data;
    logic             q_full;
    logic             q_empty;
    logic             ram_we;
    logic [BKT_W-1:0] ram_waddr;
    logic [RW-1:0]    ram_wdata;
    logic             ram_re;
    logic [BKT_W-1:0] ram_raddr;
    logic [RW-1:0]    ram_rdata;
    t_back_status     bk_stat;

    hrt_front #(
        .BUCKETS   (BUCKETS),
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .i_clearing  (bk_stat.clearing),
        .i_q_full    (q_full),
        .o_req_stall (o_req_stall),
        .o_push      (push),
        .o_push_data (push_data)
    );

    hrt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hrt_ram #(
        .WIDTH (RW),
        .DEPTH (BUCKETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hrt_back #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .NODE_BITS (NODE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .o_status    (bk_stat)
    );

    // no response can exist while the table is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.clearing |-> !o_rsp_valid)
        else $error("response valid during clearing pass");

    // a retired transaction always shows up on the response register
    a_retire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.retire |=> o_rsp_valid)
        else $error("retired transaction not presented");

    // next hop is only reported on a hit
    a_hop_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != STATUS_OK) |-> (o_rsp.next_hop_out == '0))
        else $error("next hop reported on a miss or full bucket");

endmodule

### tb/route_table_checker.sv
// Channel monitor, next-hop table predictor and response checker for the route table.
module route_table_checker import hrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_pending,
    output int   o_fails
);

    localparam int unsigned N_BUCKETS = DEF_BUCKETS;
    localparam int unsigned N_WAYS    = DEF_WAYS;
    localparam int unsigned N_SLOTS   = N_BUCKETS * N_WAYS;
    localparam logic [FIELD_W-1:0] NODE_MASK = FIELD_W'((1 << DEF_NODE_BITS) - 1);

    logic               slot_used [N_SLOTS];
    logic [FIELD_W-1:0] slot_dest [N_SLOTS];
    logic [FIELD_W-1:0] slot_hop  [N_SLOTS];

    t_rsp route_q [$];
    t_rsp want;
    int   fail_cnt = 0;

    assign o_fails = fail_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] route table mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    // Applies one request to the shadow table and returns the response it should give.
    function automatic t_rsp route_table_apply(input t_req r);
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] hop;
        int                 base;
        int                 hit;
        int                 free_way;
        t_rsp               rsp;
        key      = r.dest_node & NODE_MASK;
        hop      = r.next_hop_in & NODE_MASK;
        base     = (key % N_BUCKETS) * N_WAYS;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < N_WAYS; w++) begin
            if (hit < 0 && slot_used[base + w] && slot_dest[base + w] == key)
                hit = w;
            if (free_way < 0 && !slot_used[base + w])
                free_way = w;
        end
        rsp.status       = STATUS_OK;
        rsp.next_hop_out = '0;
        case (r.mode)
            MODE_LOOKUP: begin
                if (hit >= 0)
                    rsp.next_hop_out = slot_hop[base + hit];
                else
                    rsp.status = STATUS_MISS;
            end
            MODE_SET: begin
                if (hit >= 0) begin
                    slot_hop[base + hit] = hop;
                end else if (free_way < 0) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    slot_used[base + free_way] = 1'b1;
                    slot_dest[base + free_way] = key;
                    slot_hop[base + free_way]  = hop;
                end
            end
            MODE_DELETE: begin
                if (hit >= 0)
                    slot_used[base + hit] = 1'b0;
                else
                    rsp.status = STATUS_MISS;
            end
            default: ;  // unused code: no table change
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_SLOTS; s++) begin
                slot_used[s] = 1'b0;
                slot_dest[s] = '0;
                slot_hop[s]  = '0;
            end
            route_q.delete();
            o_pending <= 0;
        end else begin
            // response side first: a request taken this edge cannot be answered at it
            if (i_rsp_valid && !i_rsp_stall) begin
                if (route_q.size() == 0) begin
                    report_mismatch("response transaction with no request outstanding");
                end else begin
                    want = route_q.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, want.status));
                    if (i_rsp.next_hop_out !== want.next_hop_out)
                        report_mismatch($sformatf("next_hop_out 0x%02h, expected 0x%02h",
                                                  i_rsp.next_hop_out, want.next_hop_out));
                end
            end
            if (i_req_valid && !i_req_stall)
                route_q.push_back(route_table_apply(i_req));
            o_pending <= route_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
module tb_top;
    import hrt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    int pending;
    int fail_count;

    int                 burst_left = 0;
    logic [FIELD_W-1:0] recent_dest [16];
    int                 recent_wr  = 0;

    t_stall_style stall_style      = STALL_NONE;
    int           stall_phase_left = 0;

    hashed_route_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    route_table_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_stall (o_req_stall),
        .i_req       (i_req),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_rsp       (o_rsp),
        .o_pending   (pending),
        .o_fails     (fail_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stalls: a style is held for a random stretch, then another is drawn
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_style      <= t_stall_style'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(16, 96);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_style)
            STALL_NONE:  i_rsp_stall <= 1'b0;
            STALL_LIGHT: i_rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     i_rsp_stall <= stall_phase_left[2];
        endcase
    end

    // One request transaction; bursts of random length with idle gaps between them.
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] dest,
                         input logic [FIELD_W-1:0] hop);
        if (burst_left == 0) begin
            if (i_req_valid) begin
                i_req_valid <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(4, 14) : $urandom_range(1, 3))
                    @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        i_req       <= '{mode: mode, dest_node: dest, next_hop_in: hop};
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        burst_left--;
        recent_dest[recent_wr] = dest;
        recent_wr = (recent_wr + 1) % 16;
    endtask

    task automatic wait_for_drain();
        i_req_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_dest();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return {4'($urandom), 4'($urandom_range(0, 3))};  // crowd four buckets so they fill
        else if (roll < 8)
            return recent_dest[$urandom_range(0, 15)];
        else
            return FIELD_W'($urandom);
    endfunction

    initial begin
        int                roll;
        logic [MODE_W-1:0] mode;
        for (int k = 0; k < 16; k++) recent_dest[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, overwrite, full bucket, delete mid-bucket, unused code
        issue(MODE_LOOKUP, 8'h00, 8'h00);
        issue(MODE_DELETE, 8'hFF, 8'hFF);
        issue(MODE_SET,    8'h00, 8'hFF);
        issue(MODE_LOOKUP, 8'h00, 8'h00);
        issue(MODE_SET,    8'h00, 8'h00);
        issue(MODE_LOOKUP, 8'h00, 8'hFF);
        issue(MODE_SET,    8'h05, 8'h11);
        issue(MODE_SET,    8'h15, 8'h22);
        issue(MODE_SET,    8'h25, 8'h33);
        issue(MODE_SET,    8'h35, 8'h44);
        issue(MODE_SET,    8'h45, 8'h55);
        issue(MODE_LOOKUP, 8'h45, 8'h00);
        issue(MODE_DELETE, 8'h15, 8'h00);
        issue(MODE_LOOKUP, 8'h25, 8'h00);
        issue(MODE_LOOKUP, 8'h35, 8'h00);
        issue(MODE_SET,    8'h45, 8'hAA);
        issue(MODE_LOOKUP, 8'h45, 8'h00);
        issue(MODE_UNUSED, 8'h05, 8'hAA);
        issue(MODE_LOOKUP, 8'h05, 8'h55);
        issue(MODE_SET,    8'hFF, 8'h55);
        issue(MODE_LOOKUP, 8'hFF, 8'h00);
        issue(MODE_DELETE, 8'hFF, 8'h00);
        issue(MODE_LOOKUP, 8'hFF, 8'h00);
        issue(MODE_DELETE, 8'hFF, 8'h00);
        issue(MODE_SET,    8'hAA, 8'hAA);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 400 == 399)
                wait_for_drain();
            roll = $urandom_range(0, 99);
            if (roll < 40)
                mode = MODE_SET;
            else if (roll < 70)
                mode = MODE_LOOKUP;
            else if (roll < 95)
                mode = MODE_DELETE;
            else
                mode = MODE_UNUSED;
            issue(mode, pick_dest(), FIELD_W'($urandom));
        end

        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/hrt_pkg.sv
hdl/hrt_ram.sv
hdl/hrt_front.sv
hdl/hrt_queue.sv
hdl/hrt_back.sv
hdl/hashed_route_table_core.sv
tb/route_table_checker.sv
tb/tb_top.sv
